### hw/rtl/sfss_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the spectrum fault similarity score block.
// Used by the top level, the serial divider and the port checker; depends on nothing.
package sfss_pkg;

   localparam int COUNT_BITS_DEF = 24;
   localparam int TAG_BITS_DEF   = 16;

   // Quotients of the ratio divisions are Q1.31 and fit in 32 bits.
   localparam int QUOT_BITS     = 32;
   localparam int FRAC_LONG     = 31;
   localparam int FRAC_SHORT    = 16;
   localparam int FRAC_CNT_BITS = 5;
   localparam int SCORE_BITS    = 17;
   localparam int MODE_BITS     = 2;
   localparam int PROD_BITS     = 2 * QUOT_BITS;
   localparam int ROOT_REM_BITS = QUOT_BITS + 4;
   localparam int STEP_BITS     = $clog2(QUOT_BITS);

   localparam logic [SCORE_BITS-1:0] SCORE_ONE = SCORE_BITS'(65536);

   // Count table rows, indexed by {active, failed}.
   localparam logic [1:0] IDX_INACT_PASS = 2'd0;
   localparam logic [1:0] IDX_INACT_FAIL = 2'd1;
   localparam logic [1:0] IDX_ACT_PASS   = 2'd2;
   localparam logic [1:0] IDX_ACT_FAIL   = 2'd3;

   localparam logic [MODE_BITS-1:0] MODE_OCHIAI    = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_TARANTULA = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_JACCARD   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_LAUNCH,
      ST_DIV,
      ST_MUL,
      ST_ROOT
   } state_type;

   typedef enum logic [2:0] {
      PH_R1,
      PH_R2,
      PH_T2,
      PH_TQ,
      PH_J
   } phase_type;

   typedef struct packed {
      logic start;
      logic long_frac;
   } div_cmd_type;

endpackage

### hw/rtl/sfss_serial_div.sv
`timescale 1ns / 1ps
// Restoring divider that produces one quotient bit per cycle for num <= den.
// Depends on sfss_pkg for the command struct and the quotient sizes.
module sfss_serial_div
   import sfss_pkg::*;
#(
   parameter int DEN_W = 34
) (
   input  logic                 clock,
   input  logic                 reset,
   input  div_cmd_type          cmd,
   input  logic [DEN_W-1:0]     num,
   input  logic [DEN_W-1:0]     den,
   output logic                 done,
   output logic [QUOT_BITS-1:0] quot
);

   logic [DEN_W-1:0]         rem_ff, rem_in;
   logic [DEN_W-1:0]         den_ff, den_in;
   logic [QUOT_BITS-1:0]     quot_ff, quot_in;
   logic [FRAC_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [DEN_W:0]           rem_dbl;
   logic                     fits;
   logic                     int_bit;

   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_dbl = {rem_ff, 1'b0};
      fits    = rem_dbl >= {1'b0, den_ff};
      int_bit = num >= den;
      if (cmd.start) begin
         // The integer bit is 1 only when num equals den.
         den_in  = den;
         rem_in  = int_bit ? num - den : num;
         quot_in = {{(QUOT_BITS-1){1'b0}}, int_bit};
         cnt_in  = cmd.long_frac ? FRAC_CNT_BITS'(FRAC_LONG) : FRAC_CNT_BITS'(FRAC_SHORT);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? DEN_W'(rem_dbl - {1'b0, den_ff}) : DEN_W'(rem_dbl);
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == FRAC_CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

### hw/rtl/spectrum_fault_similarity_score.sv
`timescale 1ns / 1ps
// Top level of the spectrum fault similarity score block: counting, sequencer,
// serial multiply and square root. Depends on sfss_pkg and sfss_serial_div.
//
// A request that is not marked last is counted and busy stays
// low, so such requests may be issued on every clock. A request marked last is
// counted and then raises busy while the score is worked out bit-serially; one
// result strobe (rsp_valid) follows, and the receiver must take it in that cycle.
// The length of that last request is set by the shared restoring divider, which
// yields one quotient bit per cycle, and by the shift-add multiplier and the
// two-bit-per-step square root: Ochiai divides twice, multiplies and takes the
// root, Tarantula divides twice when the active passing count is zero and three
// times otherwise, Jaccard divides once, and a run without active failing
// requests (or the unused mode) does none of these. The mode register is written
// through the csr_ channel, which is ready whenever the block is not busy.
module spectrum_fault_similarity_score
   import sfss_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int TAG_BITS   = TAG_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_active,
   input  logic                  req_failed,
   input  logic                  req_last_item,
   input  logic [TAG_BITS-1:0]   req_component_tag,
   output logic                  rsp_valid,
   output logic [SCORE_BITS-1:0] rsp_score,
   output logic [TAG_BITS-1:0]   rsp_result_tag,
   output logic                  rsp_saturated,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [MODE_BITS-1:0]  csr_data
);

   // Divider operands must hold a sum of three counts or the sum of two Q1.31 ratios.
   localparam int DEN_W = (COUNT_BITS + 2 > QUOT_BITS + 1) ? COUNT_BITS + 2 : QUOT_BITS + 1;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [STEP_BITS-1:0]  STEP_LAST = STEP_BITS'(QUOT_BITS - 1);

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [COUNT_BITS-1:0]    cnt_ff [4];
   logic [COUNT_BITS-1:0]    cnt_in [4];
   logic                     sat_ff, sat_in;
   logic [MODE_BITS-1:0]     mode_ff;
   logic [TAG_BITS-1:0]      tag_ff;
   logic [QUOT_BITS-1:0]     r1_ff, r1_in;
   logic [QUOT_BITS-1:0]     r2_ff, r2_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [ROOT_REM_BITS-1:0] rem_ff, rem_in;
   logic [QUOT_BITS-1:0]     root_ff, root_in;
   logic [STEP_BITS-1:0]     step_ff, step_in;
   logic                     rsp_valid_ff;
   logic [SCORE_BITS-1:0]    rsp_score_ff;
   logic                     rsp_sat_ff;

   logic                     accept;
   logic                     finish;
   logic [SCORE_BITS-1:0]    score_next;
   logic [1:0]               sel;
   logic [COUNT_BITS-1:0]    bumped;

   div_cmd_type              div_cmd;
   logic [DEN_W-1:0]         div_num;
   logic [DEN_W-1:0]         div_den;
   logic                     div_done;
   logic [QUOT_BITS-1:0]     div_quot;

   logic [DEN_W-1:0]         ext_a, ext_b, ext_c, ext_d;
   logic [QUOT_BITS:0]       mul_sum;
   logic [ROOT_REM_BITS-1:0] root_rem_sh;
   logic [ROOT_REM_BITS-1:0] root_trial;
   logic                     root_fits;
   logic [QUOT_BITS-1:0]     root_next;
   logic                     mode_known;
   logic [QUOT_BITS-1:0]     quot_raised;

   assign accept     = start && (state_ff == ST_IDLE);
   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = (state_ff == ST_IDLE);
   assign sel        = {req_active, req_failed};

   assign ext_a = DEN_W'(cnt_ff[IDX_ACT_FAIL]);
   assign ext_b = DEN_W'(cnt_ff[IDX_INACT_FAIL]);
   assign ext_c = DEN_W'(cnt_ff[IDX_ACT_PASS]);
   assign ext_d = DEN_W'(cnt_ff[IDX_INACT_PASS]);

   assign mode_known  = (mode_ff == MODE_OCHIAI) || (mode_ff == MODE_TARANTULA) ||
                        (mode_ff == MODE_JACCARD);
   // Tarantula lifts a ratio that floors to zero up to the smallest nonzero value.
   assign quot_raised = (div_quot == '0) ? QUOT_BITS'(1) : div_quot;

   // Count table: saturating increment of the row picked by the request.
   assign bumped = (cnt_ff[sel] == COUNT_MAX) ? cnt_ff[sel] : cnt_ff[sel] + 1'b1;

   always_comb begin
      sat_in = sat_ff;
      for (int i = 0; i < 4; i++) begin
         cnt_in[i] = cnt_ff[i];
      end
      if (finish) begin
         for (int i = 0; i < 4; i++) begin
            cnt_in[i] = '0;
         end
         sat_in = 1'b0;
      end else if (accept) begin
         cnt_in[sel] = bumped;
         if (bumped == COUNT_MAX) begin
            sat_in = 1'b1;
         end
      end
   end

   // Divider operands follow the phase; they are sampled only on the launch cycle.
   always_comb begin
      div_cmd.start     = (state_ff == ST_LAUNCH);
      div_num           = ext_a;
      div_den           = ext_a + ext_b;
      div_cmd.long_frac = 1'b1;
      case (phase_ff)
         PH_R1: begin
            div_num = ext_a;
            div_den = ext_a + ext_b;
         end
         PH_R2: begin
            div_num = ext_a;
            div_den = ext_a + ext_c;
         end
         PH_T2: begin
            div_num = ext_c;
            div_den = ext_c + ext_d;
         end
         PH_TQ: begin
            div_num           = DEN_W'(r1_ff);
            div_den           = DEN_W'(r1_ff) + DEN_W'(r2_ff);
            div_cmd.long_frac = 1'b0;
         end
         PH_J: begin
            div_num           = ext_a;
            div_den           = ext_a + ext_b + ext_c;
            div_cmd.long_frac = 1'b0;
         end
         default: begin
            div_num = ext_a;
         end
      endcase
   end

   // Shift-add multiply step: r1 times r2, one multiplier bit per cycle.
   assign mul_sum = {1'b0, prod_ff[PROD_BITS-1:QUOT_BITS]} +
                    (prod_ff[0] ? {1'b0, r1_ff} : {(QUOT_BITS+1){1'b0}});

   // Square root step: two product bits enter the remainder per cycle.
   assign root_rem_sh = {rem_ff[ROOT_REM_BITS-3:0], prod_ff[PROD_BITS-1:PROD_BITS-2]};
   assign root_trial  = {2'b00, root_ff, 2'b01};
   assign root_fits   = root_rem_sh >= root_trial;
   assign root_next   = {root_ff[QUOT_BITS-2:0], root_fits};

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      r1_in         = r1_ff;
      r2_in         = r2_ff;
      prod_in       = prod_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      step_in       = step_ff;
      finish        = 1'b0;
      score_next    = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_last_item) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // No active failing run, or an unused mode, scores zero at once.
            if (cnt_ff[IDX_ACT_FAIL] == '0 || !mode_known) begin
               finish = 1'b1;
            end else begin
               phase_in = (mode_ff == MODE_JACCARD) ? PH_J : PH_R1;
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               case (phase_ff)
                  PH_R1: begin
                     if (mode_ff == MODE_TARANTULA) begin
                        r1_in = quot_raised;
                        if (cnt_ff[IDX_ACT_PASS] != '0) begin
                           phase_in = PH_T2;
                        end else begin
                           r2_in    = '0;
                           phase_in = PH_TQ;
                        end
                     end else begin
                        r1_in    = div_quot;
                        phase_in = PH_R2;
                     end
                     state_in = ST_LAUNCH;
                  end
                  PH_R2: begin
                     r2_in    = div_quot;
                     prod_in  = {{QUOT_BITS{1'b0}}, div_quot};
                     step_in  = '0;
                     state_in = ST_MUL;
                  end
                  PH_T2: begin
                     r2_in    = quot_raised;
                     phase_in = PH_TQ;
                     state_in = ST_LAUNCH;
                  end
                  PH_TQ, PH_J: begin
                     finish     = 1'b1;
                     score_next = (div_quot > QUOT_BITS'(SCORE_ONE)) ?
                                  SCORE_ONE : div_quot[SCORE_BITS-1:0];
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_MUL: begin
            prod_in = {mul_sum, prod_ff[QUOT_BITS-1:1]};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               step_in  = '0;
               rem_in   = '0;
               root_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rem_in  = root_fits ? root_rem_sh - root_trial : root_rem_sh;
            root_in = root_next;
            prod_in = {prod_ff[PROD_BITS-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_LAST) begin
               // The root is Q1.31; dropping fifteen bits gives Q1.16.
               finish     = 1'b1;
               score_next = root_next[QUOT_BITS-1 -: SCORE_BITS];
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (finish) begin
         state_in = ST_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_R1;
         sat_ff       <= 1'b0;
         mode_ff      <= MODE_OCHIAI;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= finish;
         step_ff      <= step_in;
         for (int i = 0; i < 4; i++) begin
            cnt_ff[i] <= cnt_in[i];
         end
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_data;
         end
      end
      r1_ff   <= r1_in;
      r2_ff   <= r2_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      if (accept && req_last_item) begin
         tag_ff <= req_component_tag;
      end
      if (finish) begin
         rsp_score_ff <= score_next;
         rsp_sat_ff   <= sat_ff;
      end
   end

   sfss_serial_div #(
      .DEN_W (DEN_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_score      = rsp_score_ff;
   assign rsp_result_tag = tag_ff;
   assign rsp_saturated  = rsp_sat_ff;

endmodule

### hw/rtl/sfss_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the spectrum fault similarity score block and its bind.
// Depends on sfss_pkg and on the top level it is bound to.
module sfss_checker
   import sfss_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  req_last_item,
   input logic                  rsp_valid,
   input logic [SCORE_BITS-1:0] rsp_score
);

   // A request that is not last is counted without blocking the next one.
   a_plain_request_no_stall: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_item) |=> !busy)
      else $error("busy rose after a request that was not last");

   // A last request always starts the scoring sequence.
   a_last_request_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_last_item) |=> busy)
      else $error("last request did not start scoring");

   // A result only appears after scoring has ended, and lasts one cycle.
   a_result_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!busy && $past(busy)) ##1 !rsp_valid)
      else $error("result strobe not a single cycle after scoring");

   // The score never exceeds one in Q1.16.
   a_score_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_score <= SCORE_ONE))
      else $error("score above one");

endmodule

bind spectrum_fault_similarity_score sfss_checker u_sfss_checker (.*);
